### hdl/pi_speed_servo_controller_core_assert.svh
// Assertion macros shared by the checker of the PI speed servo controller.
// Clocked implication forms, all but one reset-gated; no other dependencies.
`ifndef PI_SPEED_SERVO_CONTROLLER_CORE_ASSERT_SVH
`define PI_SPEED_SERVO_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PISC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PISC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is asserted.
`define PISC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pisc_pkg.sv
// Package of the PI speed servo controller: payload structs, register map,
// register reset values. No dependencies.
package pisc_pkg;

    localparam int SPEED_W    = 16;
    localparam int POS_W      = 12;
    localparam int GAIN_W     = 10;
    localparam int RCNT_W     = 8;
    localparam int ACC_W      = 32;
    localparam int EFFORT_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target_speed;
        logic signed [SPEED_W-1:0] measured_speed;
    } t_in;

    typedef struct packed {
        logic        [POS_W-1:0]    servo_command;
        logic signed [EFFORT_W-1:0] integral_effort;
        logic                       in_deadband;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] int_gain;
        logic [RCNT_W-1:0] integral_reset_count;
        logic [POS_W-1:0]  neutral_pos;
        logic [POS_W-1:0]  first_forward_pos;
        logic [POS_W-1:0]  first_reverse_pos;
        logic [POS_W-1:0]  full_forward_pos;
        logic [POS_W-1:0]  full_reverse_pos;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN      = 4'd0,
        REG_INT_GAIN       = 4'd1,
        REG_INT_RESET_CNT  = 4'd2,
        REG_NEUTRAL_POS    = 4'd3,
        REG_FIRST_FWD_POS  = 4'd4,
        REG_FIRST_REV_POS  = 4'd5,
        REG_FULL_FWD_POS   = 4'd6,
        REG_FULL_REV_POS   = 4'd7
    } t_cfg_idx;

    localparam t_cfg CFG_RESET = '{
        prop_gain:            10'd70,
        int_gain:             10'd5,
        integral_reset_count: 8'd20,
        neutral_pos:          12'd256,
        first_forward_pos:    12'd277,
        first_reverse_pos:    12'd256,
        full_forward_pos:     12'd315,
        full_reverse_pos:     12'd230
    };

endpackage

### hdl/pisc_cfg_regs.sv
// Configuration register file of the PI speed servo controller.
// Depends on pisc_pkg for the register map and reset values.
module pisc_cfg_regs
    import pisc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_idx,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_idx))
                REG_PROP_GAIN:     n_cfg.prop_gain            = i_wr_data[GAIN_W-1:0];
                REG_INT_GAIN:      n_cfg.int_gain             = i_wr_data[GAIN_W-1:0];
                REG_INT_RESET_CNT: n_cfg.integral_reset_count = i_wr_data[RCNT_W-1:0];
                REG_NEUTRAL_POS:   n_cfg.neutral_pos          = i_wr_data[POS_W-1:0];
                REG_FIRST_FWD_POS: n_cfg.first_forward_pos    = i_wr_data[POS_W-1:0];
                REG_FIRST_REV_POS: n_cfg.first_reverse_pos    = i_wr_data[POS_W-1:0];
                REG_FULL_FWD_POS:  n_cfg.full_forward_pos     = i_wr_data[POS_W-1:0];
                REG_FULL_REV_POS:  n_cfg.full_reverse_pos     = i_wr_data[POS_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/pi_speed_servo_controller_core.sv
// PI speed servo controller: top level with the pipelined datapath.
// Depends on pisc_pkg and pisc_cfg_regs.
//
// Input channel: i_valid / o_stall carry one t_in (target and measured speed,
// signed fixed point with FRAC_BITS fraction bits). Output channel:
// o_valid / i_stall carry one t_out per input item (servo command, saturated
// integral effort, deadband flag). A transfer happens on a rising edge with
// valid high and stall low.
// From input transfer to o_valid an item passes the input register, error
// and accumulator update, the two gain multiplies, effort saturation, then
// command sum and clamp into the output register. One item per cycle is
// sustained while the output is not stalled; the accumulator add-and-saturate
// and the call counter are the only loops, each closing within one stage.
// Every stage holds a valid bit and loads when it is empty or its successor
// moves, so bubbles collapse and new items keep entering while a result sits
// in the output register under stall. o_stall rises only once every stage is
// full and the output is stalled.
// Configuration: i_cfg_valid / o_cfg_ready (always ready); the user writes only
// while idle, which the block does not enforce. Synchronous reset clears the
// pipeline, accumulator, call counter and restores the register reset values.
module pi_speed_servo_controller_core
    import pisc_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ONE_Q       = 1 << FRAC_BITS;
    localparam int DIR_THRESH  = ONE_Q / 20;
    localparam int DEAD_THRESH = ONE_Q / 100;
    localparam int ERR_W       = SPEED_W + 1;
    localparam int GAIN_SW     = GAIN_W + 1;
    localparam int PROD_I_W    = ACC_W + GAIN_SW;
    localparam int EFF_W       = PROD_I_W - FRAC_BITS;
    localparam int PROD_P_W    = ERR_W + GAIN_SW;
    localparam int BASE_W      = EFFORT_W + 2;
    localparam int SUM_W       = ((BASE_W + FRAC_BITS) > PROD_P_W ?
                                  (BASE_W + FRAC_BITS) : PROD_P_W) + 1;
    localparam int CMD_W       = SUM_W - FRAC_BITS;
    localparam int EFF_MAX     = (1 << (EFFORT_W - 1)) - 1;
    localparam int EFF_MIN     = -(1 << (EFFORT_W - 1));

    t_cfg w_cfg;

    assign o_cfg_ready = 1'b1;

    pisc_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_idx  (i_cfg_index),
        .i_wr_data (i_cfg_data),
        .o_cfg     (w_cfg)
    );

    // ---------------- flow control ----------------
    logic r_v0, r_v1, r_v2, r_v3, r_out_v;
    logic w_en0, w_en1, w_en2, w_en3, w_en_out;

    assign w_en_out = !r_out_v || !i_stall;
    assign w_en3    = !r_v3 || w_en_out;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign w_en0    = !r_v0 || w_en1;
    assign o_stall  = !w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en0)    r_v0    <= i_valid;
            if (w_en1)    r_v1    <= r_v0;
            if (w_en2)    r_v2    <= r_v1;
            if (w_en3)    r_v3    <= r_v2;
            if (w_en_out) r_out_v <= r_v3;
        end
    end

    // ---------------- stage 0: input register ----------------
    t_in r_s0;

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_s0 <= i_data;
        end
    end

    // ---------------- stage 1: error, accumulator, direction ----------------
    logic signed [ERR_W-1:0] w_err;
    logic signed [ACC_W:0]   w_acc_sum;
    logic signed [ACC_W-1:0] w_acc_sat;
    logic [RCNT_W:0]         w_cnt_inc;
    logic                    w_expire;
    logic [POS_W-1:0]        w_start;
    logic                    w_dead;

    logic signed [ACC_W-1:0] r_acc;
    logic [RCNT_W-1:0]       r_cnt;
    logic signed [ACC_W-1:0] r_s1_acc;
    logic signed [ERR_W-1:0] r_s1_err;
    logic [POS_W-1:0]        r_s1_start;
    logic                    r_s1_dead;

    always_comb begin
        w_err     = ERR_W'(r_s0.target_speed) - ERR_W'(r_s0.measured_speed);
        w_acc_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_err);
        // overflow shows as a mismatch of the two top bits
        if (w_acc_sum[ACC_W] != w_acc_sum[ACC_W-1]) begin
            w_acc_sat = w_acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_acc_sat = w_acc_sum[ACC_W-1:0];
        end
        w_cnt_inc = {1'b0, r_cnt} + (RCNT_W+1)'(1);
        w_expire  = w_cnt_inc > {1'b0, w_cfg.integral_reset_count};
        if (r_s0.target_speed > DIR_THRESH) begin
            w_start = w_cfg.first_forward_pos;
        end else if (r_s0.target_speed < -DIR_THRESH) begin
            w_start = w_cfg.first_reverse_pos;
        end else begin
            w_start = w_cfg.neutral_pos;
        end
        w_dead = (w_err <= DEAD_THRESH) && (w_err >= -DEAD_THRESH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (w_en1 && r_v0) begin
            r_acc <= w_expire ? '0 : w_acc_sat;
            r_cnt <= w_expire ? '0 : w_cnt_inc[RCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_acc   <= w_acc_sat;
            r_s1_err   <= w_err;
            r_s1_start <= w_start;
            r_s1_dead  <= w_dead;
        end
    end

    // ---------------- stage 2: gain multiplies ----------------
    logic signed [PROD_I_W-1:0] r_s2_prod_i;
    logic signed [PROD_P_W-1:0] r_s2_prod_p;
    logic [POS_W-1:0]           r_s2_start;
    logic                       r_s2_dead;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_prod_i <= PROD_I_W'(r_s1_acc) *
                           PROD_I_W'($signed({1'b0, w_cfg.int_gain}));
            r_s2_prod_p <= PROD_P_W'(r_s1_err) *
                           PROD_P_W'($signed({1'b0, w_cfg.prop_gain}));
            r_s2_start  <= r_s1_start;
            r_s2_dead   <= r_s1_dead;
        end
    end

    // ---------------- stage 3: integral effort, round toward zero, saturate ----
    logic signed [PROD_I_W-1:0] w_prod_i_adj;
    logic signed [EFF_W-1:0]    w_eff_full;
    logic signed [EFFORT_W-1:0] w_eff_sat;

    logic signed [EFFORT_W-1:0] r_s3_eff;
    logic signed [PROD_P_W-1:0] r_s3_prod_p;
    logic [POS_W-1:0]           r_s3_start;
    logic                       r_s3_dead;

    always_comb begin
        w_prod_i_adj = r_s2_prod_i +
                       (r_s2_prod_i[PROD_I_W-1] ? PROD_I_W'(ONE_Q - 1) : '0);
        w_eff_full   = EFF_W'(w_prod_i_adj >>> FRAC_BITS);
        if (w_eff_full > EFF_MAX) begin
            w_eff_sat = EFFORT_W'(EFF_MAX);
        end else if (w_eff_full < EFF_MIN) begin
            w_eff_sat = EFFORT_W'(EFF_MIN);
        end else begin
            w_eff_sat = w_eff_full[EFFORT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_eff    <= w_eff_sat;
            r_s3_prod_p <= r_s2_prod_p;
            r_s3_start  <= r_s2_start;
            r_s3_dead   <= r_s2_dead;
        end
    end

    // ---------------- stage 4: command sum, clamp, deadband ----------------
    logic signed [BASE_W-1:0] w_base;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_sum_adj;
    logic signed [CMD_W-1:0]  w_cmd;
    logic signed [CMD_W-1:0]  w_ffwd;
    logic signed [CMD_W-1:0]  w_frev;
    logic [POS_W-1:0]         w_cmd_clamp;
    t_out                     n_out;
    t_out                     r_out;

    always_comb begin
        w_base    = BASE_W'(r_s3_eff) + BASE_W'($signed({1'b0, r_s3_start}));
        w_sum     = (SUM_W'(w_base) <<< FRAC_BITS) + SUM_W'(r_s3_prod_p);
        w_sum_adj = w_sum + (w_sum[SUM_W-1] ? SUM_W'(ONE_Q - 1) : '0);
        w_cmd     = CMD_W'(w_sum_adj >>> FRAC_BITS);
        w_ffwd    = CMD_W'($signed({1'b0, w_cfg.full_forward_pos}));
        w_frev    = CMD_W'($signed({1'b0, w_cfg.full_reverse_pos}));
        // upper limit wins when the limits are crossed
        if (w_cmd > w_ffwd) begin
            w_cmd_clamp = w_cfg.full_forward_pos;
        end else if (w_cmd < w_frev) begin
            w_cmd_clamp = w_cfg.full_reverse_pos;
        end else begin
            w_cmd_clamp = w_cmd[POS_W-1:0];
        end
        n_out.servo_command   = r_s3_dead ? w_cfg.neutral_pos : w_cmd_clamp;
        n_out.integral_effort = r_s3_eff;
        n_out.in_deadband     = r_s3_dead;
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

### hdl/pisc_checker.sv
// Port-level checker of the PI speed servo controller, bound to the top level.
// Depends on pisc_pkg and the assertion macro header.
`include "pi_speed_servo_controller_core_assert.svh"

module pisc_checker
    import pisc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    logic w_out_wait;

    assign w_out_wait = o_valid && i_stall;

    // input transfer, then the output kept free to move (i_stall low)
    sequence s_in_then_flow;
        (i_valid && !o_stall) ##1 (!i_stall) [*4];
    endsequence

    // a result held under stall keeps its fields
    `PISC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_valid && $stable(o_data), "result changed")

    // the pipeline can always take an item while the output register is empty
    `PISC_ASSERT_SAME(a_no_stall_empty, i_clk, i_rst_n, !o_valid, !o_stall, "stall with empty output")

    // a transfer followed by the unstalled output run of s_in_then_flow yields a result
    `PISC_ASSERT_NEXT(a_latency, i_clk, i_rst_n, s_in_then_flow, o_valid, "result late")

    // reset empties the output register
    `PISC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid, "output valid after reset")

endmodule

bind pi_speed_servo_controller_core pisc_checker u_pisc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

### tb/sv/pi_speed_servo_controller_core_test.sv
// Self-checking testbench for pi_speed_servo_controller_core: directed and random
// speed samples under several register settings, predicted in-line and checked.
// Depends on pisc_pkg and the controller RTL.
module pi_speed_servo_controller_core_test;
    import pisc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC_BITS  = 12;
    localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
    localparam longint DIR_LIMIT  = ONE_Q / 20;
    localparam longint DEAD_LIMIT = ONE_Q / 100;
    localparam longint ACC_MAX    = 64'sd2147483647;
    localparam longint ACC_MIN    = -64'sd2147483648;
    localparam int     DRAIN_TAIL = 8;
    localparam int     IDLE_LIMIT = 2000;
    localparam int     HOLD_LEN   = 64;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd12;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_in                   i_data      = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    pi_speed_servo_controller_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Controller model state and register copy
    t_cfg cfg_now   = CFG_RESET;
    int   err_sum   = 0;
    int   calls_seen = 0;

    t_in  speed_q[$];
    t_out servo_expect_q[$];

    bit   sample_taken  = 1'b0;
    bit   send_idle_en  = 1'b1;
    bit   recv_idle_en  = 1'b1;
    int   send_gap      = 0;
    int   recv_gap      = 0;
    int   hold_request  = 0;
    int   hold_left     = 0;
    int   idle_cycles   = 0;
    int   fail_count    = 0;
    int   samples_sent  = 0;
    int   results_seen  = 0;
    int   settings_used = 0;

    function automatic longint scale_down(input longint p);
        if (p < 0) return -((-p) >>> FRAC_BITS);
        return p >>> FRAC_BITS;
    endfunction

    function automatic t_out predict_servo(input t_in s);
        longint tgt, meas, err, start, acc, effort, sum, cmd;
        bit     dead;
        t_out   r;
        tgt  = $signed(s.target_speed);
        meas = $signed(s.measured_speed);
        err  = tgt - meas;
        if (tgt > DIR_LIMIT) start = longint'(cfg_now.first_forward_pos);
        else if (tgt < -DIR_LIMIT) start = longint'(cfg_now.first_reverse_pos);
        else start = longint'(cfg_now.neutral_pos);

        acc = longint'(err_sum) + err;
        if (acc > ACC_MAX) acc = ACC_MAX;
        else if (acc < ACC_MIN) acc = ACC_MIN;
        err_sum = int'(acc);

        effort = scale_down(acc * longint'(cfg_now.int_gain));
        if (effort > 32767) effort = 32767;
        else if (effort < -32768) effort = -32768;

        sum = effort * ONE_Q + start * ONE_Q + err * longint'(cfg_now.prop_gain);
        cmd = scale_down(sum);

        // counter expiry clears the accumulator after this sample's effort
        if (calls_seen + 1 > int'(cfg_now.integral_reset_count)) begin
            calls_seen = 0;
            err_sum    = 0;
        end else begin
            calls_seen = calls_seen + 1;
        end

        // crossed clamps: upper limit wins
        if (cmd > longint'(cfg_now.full_forward_pos)) cmd = longint'(cfg_now.full_forward_pos);
        else if (cmd < longint'(cfg_now.full_reverse_pos)) cmd = longint'(cfg_now.full_reverse_pos);

        dead = (err <= DEAD_LIMIT) && (err >= -DEAD_LIMIT);
        if (dead) cmd = longint'(cfg_now.neutral_pos);

        r.servo_command   = cmd[POS_W-1:0];
        r.integral_effort = effort[EFFORT_W-1:0];
        r.in_deadband     = dead;
        return r;
    endfunction

    task automatic report_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Transfer monitor: predicts on input transfers, checks output transfers.
    always @(posedge i_clk) begin
        t_out want;
        bit   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                servo_expect_q.push_back(predict_servo(i_data));
                send_gap     = send_idle_en ? $urandom_range(0, 3) : 0;
                sample_taken = 1'b1;
                samples_sent++;
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (servo_expect_q.size() == 0) begin
                    $display("%0t: result with nothing pending, expected none, got cmd %0d",
                             $time, o_data.servo_command);
                    fail_count++;
                end else begin
                    want = servo_expect_q.pop_front();
                    report_field("servo_command", want.servo_command, o_data.servo_command);
                    report_field("integral_effort", want.integral_effort,
                                 o_data.integral_effort);
                    report_field("in_deadband", want.in_deadband, o_data.in_deadband);
                end
                results_seen++;
                recv_gap = recv_idle_en ? $urandom_range(0, 3) : 0;
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Sample driver: a stalled payload holds until its transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !sample_taken) begin
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (speed_q.size() > 0) begin
            i_valid <= 1'b1;
            i_data  <= speed_q.pop_front();
        end else begin
            i_valid <= 1'b0;
        end
        sample_taken = 1'b0;
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_request > 0) begin
            hold_left    = hold_request - 1;
            hold_request = 0;
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_PROP_GAIN:     cfg_now.prop_gain            = val[GAIN_W-1:0];
            REG_INT_GAIN:      cfg_now.int_gain             = val[GAIN_W-1:0];
            REG_INT_RESET_CNT: cfg_now.integral_reset_count = val[RCNT_W-1:0];
            REG_NEUTRAL_POS:   cfg_now.neutral_pos          = val[POS_W-1:0];
            REG_FIRST_FWD_POS: cfg_now.first_forward_pos    = val[POS_W-1:0];
            REG_FIRST_REV_POS: cfg_now.first_reverse_pos    = val[POS_W-1:0];
            REG_FULL_FWD_POS:  cfg_now.full_forward_pos     = val[POS_W-1:0];
            REG_FULL_REV_POS:  cfg_now.full_reverse_pos     = val[POS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input int pg, input int ig, input int rc, input int np,
                                  input int ffp, input int frp, input int fwd, input int rev);
        write_reg(REG_PROP_GAIN, 12'(pg));
        write_reg(REG_INT_GAIN, 12'(ig));
        write_reg(REG_INT_RESET_CNT, 12'(rc));
        write_reg(REG_NEUTRAL_POS, 12'(np));
        write_reg(REG_FIRST_FWD_POS, 12'(ffp));
        write_reg(REG_FIRST_REV_POS, 12'(frp));
        write_reg(REG_FULL_FWD_POS, 12'(fwd));
        write_reg(REG_FULL_REV_POS, 12'(rev));
        settings_used++;
    endtask

    task automatic queue_sample(input int tgt, input int meas);
        t_in s;
        s.target_speed   = 16'(tgt);
        s.measured_speed = 16'(meas);
        speed_q.push_back(s);
    endtask

    // Mix of full-range noise, near-deadband errors, direction-threshold targets
    // and steady one-sided errors that wind up the accumulator.
    function automatic t_in random_sample();
        t_in s;
        int  t, m;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                t = $signed(16'($urandom));
                m = $signed(16'($urandom));
            end
            3, 4, 5: begin
                t = $signed(16'($urandom));
                m = t - (int'($urandom_range(0, 120)) - 60);
            end
            6, 7: begin
                t = $urandom_range(180, 230);
                if ($urandom_range(0, 1)) t = -t;
                m = t - (int'($urandom_range(0, 400)) - 200);
            end
            default: begin
                t = $urandom_range(2000, 12000);
                m = t - int'($urandom_range(0, 3000));
                if ($urandom_range(0, 1)) begin
                    t = -t;
                    m = -m;
                end
            end
        endcase
        s.target_speed   = 16'(t);
        s.measured_speed = 16'(m);
        return s;
    endfunction

    task automatic push_random(input int n);
        repeat (n) speed_q.push_back(random_sample());
    endtask

    task automatic wait_drained();
        while (speed_q.size() != 0 || i_valid || servo_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        settings_used = 1;

        // directed samples under reset register values
        queue_sample(0, 0);
        queue_sample(32767, -32768);
        queue_sample(-32768, 32767);
        queue_sample(32767, 32767);
        queue_sample(-32768, -32768);
        queue_sample(204, 0);
        queue_sample(205, 0);
        queue_sample(-204, 0);
        queue_sample(-205, 0);
        queue_sample(1000, 960);
        queue_sample(1000, 959);
        queue_sample(1000, 1040);
        queue_sample(1000, 1041);
        queue_sample(-32768, 0);
        queue_sample(0, -32768);
        queue_sample(0, 32767);
        queue_sample(21845, -21846);
        queue_sample(-21846, 21845);
        queue_sample(5000, 4000);
        queue_sample(-5000, -4000);
        queue_sample(3000, -3000);
        queue_sample(-3000, 3000);
        queue_sample(300, 340);
        queue_sample(-300, -260);
        queue_sample(12000, 100);
        wait_drained();

        // all registers zero, plus a write to an unmapped index
        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        write_reg(REG_UNMAPPED, 12'hFFF);
        push_random(200);
        wait_drained();

        // full-scale values; gain and count writes carry extra high bits
        apply_settings(4095, 4095, 4095, 2048, 4095, 0, 4095, 0);
        push_random(300);
        wait_drained();

        // crossed clamps, back-to-back traffic against a long output hold-off
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        apply_settings(300, 40, 50, 2000, 2600, 1400, 1000, 3000);
        push_random(250);
        hold_request = HOLD_LEN;
        wait_drained();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;

        // accumulator cleared every sample; sender pauses until all results are in
        apply_settings(512, 800, 0, 256, 277, 256, 315, 230);
        push_random(100);
        wait_drained();
        push_random(100);
        wait_drained();

        apply_settings(70, 5, 20, 256, 277, 256, 315, 230);
        push_random(200);
        wait_drained();

        repeat (3) begin
            apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 255), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(2048, 4095), $urandom_range(0, 2047));
            push_random(150);
            wait_drained();
        end

        $display("Covered %0d speed samples under %0d register settings; %0d results checked.",
                 samples_sent, settings_used, results_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/pisc_pkg.sv
hdl/pisc_cfg_regs.sv
hdl/pi_speed_servo_controller_core.sv
hdl/pisc_checker.sv
tb/sv/pi_speed_servo_controller_core_test.sv
